// ===== hdl/bvm_pkg.sv =====
// battery voltage monitor package: field widths, register codes, reset values
// and the beat types passed between pipeline stages
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bvm_pkg;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int MV_W     = 16;
   localparam int COUNT_W  = 4;

   // discharge counter saturation and alarm margin while flying
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 4'd15;
   localparam logic [MV_W-1:0]    ALARM_MARGIN_MV = 16'd30;

   // parameter defaults
   localparam int GROUP_SIZE_DEF = 5;
   localparam int LAND_LIMIT_DEF = 8;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE         = 2'd0,
      CSR_OVERDISCHARGE = 2'd1,
      CSR_ALARM         = 2'd2,
      CSR_CHARGE        = 2'd3
   } csr_index_type;

   // register reset values
   localparam logic [MV_W-1:0] SCALE_RST         = 16'd6504;
   localparam logic [MV_W-1:0] OVERDISCHARGE_RST = 16'd3500;
   localparam logic [MV_W-1:0] ALARM_RST         = 16'd3650;
   localparam logic [MV_W-1:0] CHARGE_RST        = 16'd2000;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [MV_W-1:0] scale_mv;
      logic [MV_W-1:0] overdischarge_mv;
      logic [MV_W-1:0] alarm_mv;
      logic [MV_W-1:0] charge_mv;
   } csr_type;

   // beat after the divide stage
   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_code;
      logic                flying;
   } mean_beat_type;

   // beat after the scale stage
   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_code;
      logic [MV_W-1:0]     voltage_mv;
      logic                flying;
   } volt_beat_type;

   // result beat
   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_code;
      logic [MV_W-1:0]     voltage_mv;
      logic                alarm;
      logic                charge_low;
      logic                land_request;
      logic [COUNT_W-1:0]  discharge_count;
   } rsp_beat_type;

endpackage

`default_nettype wire

// ===== hdl/bvm_req_if.sv =====
// sample channel of the battery voltage monitor: valid, ready and payload
// depends on bvm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bvm_req_if import bvm_pkg::*;;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                flying;

   modport source (output valid, output sample, output flying, input ready);
   modport sink   (input valid, input sample, input flying, output ready);

endinterface

`default_nettype wire

// ===== hdl/bvm_rsp_if.sv =====
// result channel of the battery voltage monitor: valid, ready and payload
// depends on bvm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bvm_rsp_if import bvm_pkg::*;;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] mean_code;
   logic [MV_W-1:0]     voltage_mv;
   logic                alarm;
   logic                charge_low;
   logic                land_request;
   logic [COUNT_W-1:0]  discharge_count;

   modport source (output valid, output mean_code, output voltage_mv, output alarm,
                   output charge_low, output land_request, output discharge_count,
                   input ready);
   modport sink   (input valid, input mean_code, input voltage_mv, input alarm,
                   input charge_low, input land_request, input discharge_count,
                   output ready);

endinterface

`default_nettype wire

// ===== hdl/bvm_accum.sv =====
// sample accumulator: sums groups of GROUP_SIZE samples and hands each
// completed group sum with its flying bit to the divide stage
// depends on bvm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bvm_accum import bvm_pkg::*; #(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF,
   parameter int SUM_W      = SAMPLE_W + $clog2(GROUP_SIZE)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [SAMPLE_W-1:0] in_sample,
   input  wire logic                in_flying,
   output logic                     grp_valid,
   input  wire logic                grp_ready,
   output logic [SUM_W-1:0]         grp_sum,
   output logic                     grp_flying
);

   localparam int CNT_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(GROUP_SIZE - 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic             grp_valid_ff, grp_valid_in;
   logic [SUM_W-1:0] grp_sum_ff, grp_sum_in;
   logic             grp_flying_ff, grp_flying_in;
   logic [SUM_W-1:0] sum_add;
   logic             take;
   logic             last;

   // a new sample is taken unless a finished group is still waiting
   assign in_ready = !grp_valid_ff || grp_ready;
   assign take     = in_valid && in_ready;
   assign last     = (seen_ff == LAST_IDX);
   assign sum_add  = sum_ff + SUM_W'(in_sample);

   // running sum, sample count and group hand-off
   always_comb begin
      sum_in        = sum_ff;
      seen_in       = seen_ff;
      grp_valid_in  = grp_valid_ff && !grp_ready;
      grp_sum_in    = grp_sum_ff;
      grp_flying_in = grp_flying_ff;
      if (take) begin
         if (last) begin
            sum_in        = '0;
            seen_in       = '0;
            grp_valid_in  = 1'b1;
            grp_sum_in    = sum_add;
            grp_flying_in = in_flying;
         end else begin
            sum_in  = sum_add;
            seen_in = seen_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         seen_ff      <= '0;
         grp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         seen_ff      <= seen_in;
         grp_valid_ff <= grp_valid_in;
      end
      grp_sum_ff    <= grp_sum_in;
      grp_flying_ff <= grp_flying_in;
   end

   assign grp_valid  = grp_valid_ff;
   assign grp_sum    = grp_sum_ff;
   assign grp_flying = grp_flying_ff;

   // sample count never reaches the group size
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= LAST_IDX)
      else $error("sample count out of range");

endmodule

`default_nettype wire

// ===== hdl/bvm_scale.sv =====
// divide and scale pipeline: group sum to mean code by reciprocal multiply,
// then mean code to millivolts, one multiplier per stage
// depends on bvm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bvm_scale import bvm_pkg::*; #(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF,
   parameter int SUM_W      = SAMPLE_W + $clog2(GROUP_SIZE)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             grp_valid,
   output logic                  grp_ready,
   input  wire logic [SUM_W-1:0] grp_sum,
   input  wire logic             grp_flying,
   input  wire logic [MV_W-1:0]  scale_mv,
   output logic                  volt_valid,
   input  wire logic             volt_ready,
   output volt_beat_type         volt_beat
);

   // exact reciprocal for every sum below 2**SUM_W
   localparam int SHIFT  = SUM_W + $clog2(GROUP_SIZE);
   localparam int RECIP_W = SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int VPROD_W = SAMPLE_W + MV_W;

   logic                mean_valid_ff, mean_valid_in;
   mean_beat_type       mean_ff, mean_in;
   logic                volt_valid_ff, volt_valid_in;
   volt_beat_type       volt_ff, volt_in;
   logic                mean_ready;
   logic [PROD_W-1:0]   div_prod;
   logic [VPROD_W-1:0]  volt_prod;

   // stage handshakes
   assign mean_ready = !volt_valid_ff || volt_ready;
   assign grp_ready  = !mean_valid_ff || mean_ready;

   // divide stage
   assign div_prod = PROD_W'(grp_sum) * PROD_W'(RECIP);

   always_comb begin
      mean_valid_in = mean_valid_ff && !mean_ready;
      mean_in       = mean_ff;
      if (grp_valid && grp_ready) begin
         mean_valid_in     = 1'b1;
         mean_in.mean_code = div_prod[SHIFT +: SAMPLE_W];
         mean_in.flying    = grp_flying;
      end
   end

   // scale stage, mean times full-scale millivolts over 4096
   assign volt_prod = VPROD_W'(mean_ff.mean_code) * VPROD_W'(scale_mv);

   always_comb begin
      volt_valid_in = volt_valid_ff && !volt_ready;
      volt_in       = volt_ff;
      if (mean_valid_ff && mean_ready) begin
         volt_valid_in      = 1'b1;
         volt_in.mean_code  = mean_ff.mean_code;
         volt_in.voltage_mv = volt_prod[SAMPLE_W +: MV_W];
         volt_in.flying     = mean_ff.flying;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_valid_ff <= 1'b0;
         volt_valid_ff <= 1'b0;
      end else begin
         mean_valid_ff <= mean_valid_in;
         volt_valid_ff <= volt_valid_in;
      end
      mean_ff <= mean_in;
      volt_ff <= volt_in;
   end

   assign volt_valid = volt_valid_ff;
   assign volt_beat  = volt_ff;

endmodule

`default_nettype wire

// ===== hdl/bvm_check.sv =====
// threshold checks, discharge counter and result register
// depends on bvm_pkg and bvm_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module bvm_check import bvm_pkg::*; #(
   parameter int LAND_LIMIT = LAND_LIMIT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire csr_type       csr,
   input  wire logic          volt_valid,
   output logic               volt_ready,
   input  wire volt_beat_type volt_beat,
   bvm_rsp_if.source          rsp_ch
);

   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(LAND_LIMIT);

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_ff, rsp_in;
   logic [COUNT_W-1:0] over_count_ff, over_count_in;
   logic [MV_W:0]      od_margin;
   logic               at_od;
   logic               take;

   assign volt_ready = !rsp_valid_ff || rsp_ch.ready;
   assign take       = volt_valid && volt_ready;

   // overdischarge threshold plus margin, one bit wider so it cannot wrap
   assign od_margin = {1'b0, csr.overdischarge_mv} + {1'b0, ALARM_MARGIN_MV};
   assign at_od     = volt_beat.voltage_mv <= csr.overdischarge_mv;

   // flying and grounded checks
   always_comb begin
      over_count_in = over_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;
      if (take) begin
         rsp_valid_in      = 1'b1;
         rsp_in.mean_code  = volt_beat.mean_code;
         rsp_in.voltage_mv = volt_beat.voltage_mv;
         rsp_in.charge_low = volt_beat.voltage_mv < csr.charge_mv;
         if (volt_beat.flying) begin
            if (!at_od) begin
               over_count_in = '0;
            end else if (over_count_ff != COUNT_MAX) begin
               over_count_in = over_count_ff + COUNT_W'(1);
            end
            rsp_in.alarm        = {1'b0, volt_beat.voltage_mv} <= od_margin;
            rsp_in.land_request = over_count_in > LIMIT;
         end else begin
            rsp_in.alarm        = (volt_beat.voltage_mv < csr.alarm_mv) &&
                                  (volt_beat.voltage_mv > csr.charge_mv);
            rsp_in.land_request = 1'b0;
         end
         rsp_in.discharge_count = over_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         over_count_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         over_count_ff <= over_count_in;
      end
      rsp_ff <= rsp_in;
   end

   // result channel
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.mean_code       = rsp_ff.mean_code;
   assign rsp_ch.voltage_mv      = rsp_ff.voltage_mv;
   assign rsp_ch.alarm           = rsp_ff.alarm;
   assign rsp_ch.charge_low      = rsp_ff.charge_low;
   assign rsp_ch.land_request    = rsp_ff.land_request;
   assign rsp_ch.discharge_count = rsp_ff.discharge_count;

   // a landing request only follows a check at or below the threshold
   a_land_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.land_request |-> rsp_ff.alarm)
      else $error("land request without alarm");

   // counter moves only with a taken beat
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(over_count_ff))
      else $error("discharge count changed without a beat");

   // grounded checks leave the counter alone
   a_count_ground: assert property (@(posedge clock) disable iff (reset)
      take && !volt_beat.flying |=> over_count_ff == $past(over_count_ff))
      else $error("grounded check changed discharge count");

endmodule

`default_nettype wire

// ===== hdl/battery_voltage_monitor_top.sv =====
// Battery voltage monitor: averages groups of GROUP_SIZE 12-bit ADC samples,
// scales the mean to millivolts and checks it against the flight and ground
// thresholds held in four configuration registers. One sample is taken every
// clock cycle while no back-pressure holds the accumulator; the result of a
// group passes the registers of the accumulator, reciprocal-multiply divide,
// millivolt scaling multiply and threshold check in turn before it is valid
// on the result port.
// Back-pressure on the result channel stalls the pipeline stage by stage.
// depends on bvm_pkg, bvm_req_if, bvm_rsp_if, bvm_accum, bvm_scale, bvm_check
`timescale 1ns / 1ps
`default_nettype none

module battery_voltage_monitor_top import bvm_pkg::*; #(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF,
   parameter int LAND_LIMIT = LAND_LIMIT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MV_W-1:0]      csr_write_data,
   bvm_req_if.sink                   req_ch,
   bvm_rsp_if.source                 rsp_ch
);

   localparam int SUM_W = SAMPLE_W + $clog2(GROUP_SIZE);

   csr_type          csr_ff, csr_in;
   logic             grp_valid;
   logic             grp_ready;
   logic [SUM_W-1:0] grp_sum;
   logic             grp_flying;
   logic             volt_valid;
   logic             volt_ready;
   volt_beat_type    volt_beat;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCALE:         csr_in.scale_mv         = csr_write_data;
            CSR_OVERDISCHARGE: csr_in.overdischarge_mv = csr_write_data;
            CSR_ALARM:         csr_in.alarm_mv         = csr_write_data;
            CSR_CHARGE:        csr_in.charge_mv        = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.scale_mv         <= SCALE_RST;
         csr_ff.overdischarge_mv <= OVERDISCHARGE_RST;
         csr_ff.alarm_mv         <= ALARM_RST;
         csr_ff.charge_mv        <= CHARGE_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // group accumulation
   bvm_accum #(
      .GROUP_SIZE (GROUP_SIZE),
      .SUM_W      (SUM_W)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_sample  (req_ch.sample),
      .in_flying  (req_ch.flying),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp_sum    (grp_sum),
      .grp_flying (grp_flying)
   );

   // divide and scale
   bvm_scale #(
      .GROUP_SIZE (GROUP_SIZE),
      .SUM_W      (SUM_W)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp_sum    (grp_sum),
      .grp_flying (grp_flying),
      .scale_mv   (csr_ff.scale_mv),
      .volt_valid (volt_valid),
      .volt_ready (volt_ready),
      .volt_beat  (volt_beat)
   );

   // threshold checks and result register
   bvm_check #(
      .LAND_LIMIT (LAND_LIMIT)
   ) u_check (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .volt_valid (volt_valid),
      .volt_ready (volt_ready),
      .volt_beat  (volt_beat),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== test/bvm_reading_checker.sv =====
// battery voltage monitor checker: watches the sample, result and register ports,
// predicts each group reading and compares it with the result beats
// depends on bvm_pkg, bvm_req_if, bvm_rsp_if
`timescale 1ns / 1ps

module bvm_reading_checker import bvm_pkg::*; #(
   parameter int GROUP_SIZE = GROUP_SIZE_DEF,
   parameter int LAND_LIMIT = LAND_LIMIT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MV_W-1:0]      csr_write_data,
   bvm_req_if                   req_ch,
   bvm_rsp_if                   rsp_ch,
   output int                   mismatch_total,
   output int                   readings_waiting
);

   // shadow copy of the thresholds
   logic [MV_W-1:0] shadow_scale;
   logic [MV_W-1:0] shadow_overdischarge;
   logic [MV_W-1:0] shadow_alarm;
   logic [MV_W-1:0] shadow_charge;

   // averaging and discharge state
   int unsigned group_sum;
   int          group_fill;
   int unsigned discharge_run;

   // readings predicted but not yet seen on the result port
   rsp_beat_type pending_readings[$];

   initial mismatch_total = 0;
   initial readings_waiting = 0;

   // add one sample to the group; on the last sample form the reading
   function automatic bit average_and_judge(input logic [SAMPLE_W-1:0] code,
                                            input logic fly,
                                            output rsp_beat_type reading);
      int unsigned mean;
      int unsigned volt;
      reading = '0;
      group_sum  += code;
      group_fill += 1;
      if (group_fill < GROUP_SIZE) return 1'b0;

      mean       = group_sum / GROUP_SIZE;
      group_sum  = 0;
      group_fill = 0;
      volt       = (mean * shadow_scale) >> 12;

      // flight checks drive the discharge counter, ground checks leave it alone
      if (fly) begin
         reading.alarm = (volt <= shadow_overdischarge + ALARM_MARGIN_MV);
         if (volt <= shadow_overdischarge) begin
            if (discharge_run < COUNT_MAX) discharge_run += 1;
         end else begin
            discharge_run = 0;
         end
         reading.land_request = (discharge_run > LAND_LIMIT);
      end else begin
         reading.alarm = (volt < shadow_alarm) && (volt > shadow_charge);
      end
      reading.charge_low      = (volt < shadow_charge);
      reading.mean_code       = mean[SAMPLE_W-1:0];
      reading.voltage_mv      = volt[MV_W-1:0];
      reading.discharge_count = discharge_run[COUNT_W-1:0];
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type fresh;
      rsp_beat_type due;
      rsp_beat_type got;
      bit           bad;
      if (reset) begin
         shadow_scale         <= SCALE_RST;
         shadow_overdischarge <= OVERDISCHARGE_RST;
         shadow_alarm         <= ALARM_RST;
         shadow_charge        <= CHARGE_RST;
         group_sum     = 0;
         group_fill    = 0;
         discharge_run = 0;
         pending_readings.delete();
      end else begin
         // register writes, to be made only while the block is idle; nothing here enforces that
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_SCALE:         shadow_scale         <= csr_write_data;
               CSR_OVERDISCHARGE: shadow_overdischarge <= csr_write_data;
               CSR_ALARM:         shadow_alarm         <= csr_write_data;
               CSR_CHARGE:        shadow_charge        <= csr_write_data;
               default: ;
            endcase
         end

         // sample beat
         if (req_ch.valid && req_ch.ready) begin
            if (average_and_judge(req_ch.sample, req_ch.flying, fresh))
               pending_readings.push_back(fresh);
         end

         // result beat
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.mean_code       = rsp_ch.mean_code;
            got.voltage_mv      = rsp_ch.voltage_mv;
            got.alarm           = rsp_ch.alarm;
            got.charge_low      = rsp_ch.charge_low;
            got.land_request    = rsp_ch.land_request;
            got.discharge_count = rsp_ch.discharge_count;
            if (pending_readings.size() == 0) begin
               mismatch_total <= mismatch_total + 1;
               if (mismatch_total < 10)
                  $display("%0t: result with none pending: mean %0d mv %0d", $realtime,
                           got.mean_code, got.voltage_mv);
            end else begin
               due = pending_readings.pop_front();
               bad = (got.mean_code != due.mean_code) ||
                     (got.voltage_mv != due.voltage_mv) ||
                     (got.alarm != due.alarm) ||
                     (got.charge_low != due.charge_low) ||
                     (got.land_request != due.land_request) ||
                     (got.discharge_count != due.discharge_count);
               if (bad) begin
                  mismatch_total <= mismatch_total + 1;
                  if (mismatch_total < 10) begin
                     $display("%0t: want mean %0d mv %0d alarm %0b chg %0b land %0b cnt %0d",
                              $realtime, due.mean_code, due.voltage_mv, due.alarm,
                              due.charge_low, due.land_request, due.discharge_count);
                     $display("%0t: got  mean %0d mv %0d alarm %0b chg %0b land %0b cnt %0d",
                              $realtime, got.mean_code, got.voltage_mv, got.alarm,
                              got.charge_low, got.land_request, got.discharge_count);
                  end
               end
            end
         end
      end
      // readings still owed by the block
      readings_waiting <= pending_readings.size();
   end

endmodule

// ===== test/testbench.sv =====
// battery voltage monitor testbench: drives samples and register settings,
// stalls both channels at random and reports the verdict
// depends on bvm_pkg, bvm_req_if, bvm_rsp_if, bvm_reading_checker and the block
`timescale 1ns / 1ps

module testbench;
   import bvm_pkg::*;

   localparam int GROUP_SIZE   = GROUP_SIZE_DEF;
   localparam int LAND_LIMIT   = LAND_LIMIT_DEF;
   localparam int SETTLE       = 8;
   localparam int HOLD_CYCLES  = 200;
   localparam int LIMIT_CYCLES = 200000;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   csr_index_type        csr_index;
   logic [MV_W-1:0]      csr_write_data;
   int                   mismatch_total;
   int                   readings_waiting;
   int                   cycle_count;

   // thresholds currently programmed, used to aim samples at them
   int cur_scale;
   int cur_overdischarge;
   int cur_alarm;
   int cur_charge;

   // stretches of back-to-back beats on each side
   bit req_no_gaps;
   bit rsp_no_gaps;
   int req_beats;
   int rsp_beats;

   bvm_req_if req_ch ();
   bvm_rsp_if rsp_ch ();

   battery_voltage_monitor_top #(
      .GROUP_SIZE (GROUP_SIZE),
      .LAND_LIMIT (LAND_LIMIT)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch)
   );

   bvm_reading_checker #(
      .GROUP_SIZE (GROUP_SIZE),
      .LAND_LIMIT (LAND_LIMIT)
   ) reading_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .mismatch_total   (mismatch_total),
      .readings_waiting (readings_waiting)
   );

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // one sample beat, with a random gap in front
   task automatic send_sample(input logic [SAMPLE_W-1:0] code, input logic fly);
      int gap;
      if (req_beats % 64 == 0) req_no_gaps = ($urandom_range(0, 3) == 0);
      req_beats += 1;
      gap = req_no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= code;
      req_ch.flying <= fly;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // one group: first sample, then the rest alike; only the last flying bit counts
   task automatic send_group(input int first_code, input int rest_code,
                             input logic mid_fly, input logic end_fly);
      int i;
      for (i = 0; i < GROUP_SIZE; i++)
         send_sample(SAMPLE_W'((i == 0) ? first_code : rest_code),
                     (i == GROUP_SIZE - 1) ? end_fly : mid_fly);
   endtask

   // all four registers on consecutive edges
   task automatic program_csrs(input int scale, input int overdischarge,
                               input int alarm, input int charge);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SCALE;
      csr_write_data <= MV_W'(scale);
      @(posedge clock);
      csr_index      <= CSR_OVERDISCHARGE;
      csr_write_data <= MV_W'(overdischarge);
      @(posedge clock);
      csr_index      <= CSR_ALARM;
      csr_write_data <= MV_W'(alarm);
      @(posedge clock);
      csr_index      <= CSR_CHARGE;
      csr_write_data <= MV_W'(charge);
      @(posedge clock);
      csr_write_en   <= 1'b0;
      cur_scale         = scale;
      cur_overdischarge = overdischarge;
      cur_alarm         = alarm;
      cur_charge        = charge;
   endtask

   // wait until every reading is back and the pipeline has emptied
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (readings_waiting != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // mean code that lands near a millivolt level at the current scale
   function automatic int code_for_mv(input int mv);
      int c;
      if (cur_scale == 0) return $urandom_range(0, 4095);
      c = (mv * 4096) / cur_scale;
      return (c > 4095) ? 4095 : c;
   endfunction

   function automatic int clamp_code(input int c);
      if (c < 0) return 0;
      if (c > 4095) return 4095;
      return c;
   endfunction

   // runs of well-formed groups aimed at the thresholds, plus noise groups
   task automatic random_groups(input int n_groups);
      int   done;
      int   run_len;
      int   kind;
      int   target;
      int   k;
      int   i;
      int   code;
      logic fly_run;
      done = 0;
      while (done < n_groups) begin
         run_len = $urandom_range(1, 20);
         if (run_len > n_groups - done) run_len = n_groups - done;
         kind    = $urandom_range(0, 3);
         fly_run = ($urandom_range(0, 9) < 7);
         case ($urandom_range(0, 3))
            0: target = code_for_mv(cur_overdischarge);
            1: target = code_for_mv(cur_overdischarge + 30);
            2: target = code_for_mv(cur_alarm);
            default: target = code_for_mv(cur_charge);
         endcase
         for (k = 0; k < run_len; k++) begin
            if (kind == 3) target = $urandom_range(0, code_for_mv(cur_overdischarge));
            code = $urandom_range(0, 1) ? 4095 : 0;
            for (i = 0; i < GROUP_SIZE; i++) begin
               case (kind)
                  0: code = $urandom_range(0, 4095);
                  1, 3: code = clamp_code(target + $urandom_range(0, 6) - 3);
                  default: ;
               endcase
               send_sample(SAMPLE_W'(code),
                           (i == GROUP_SIZE - 1) ? fly_run : 1'($urandom_range(0, 1)));
            end
         end
         done += run_len;
      end
   endtask

   // random groups, a few loose samples left in the accumulator, then drain
   task automatic run_phase(input int n_groups);
      int loose;
      random_groups(n_groups);
      loose = $urandom_range(0, GROUP_SIZE - 1);
      repeat (loose) send_sample(SAMPLE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      wait_drained();
   endtask

   // result side: random stalls, and now and then a long hold-off
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      rsp_beats    = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_beats % 50 == 0) rsp_no_gaps = ($urandom_range(0, 3) == 0);
         gap = rsp_no_gaps ? 0 : $urandom_range(0, 4);
         if (rsp_beats % 120 == 10) gap += HOLD_CYCLES;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         rsp_beats += 1;
      end
   end

   // stimulus and verdict
   initial begin
      int p;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_SCALE;
      csr_write_data = '0;
      req_ch.valid   = 1'b0;
      req_ch.sample  = '0;
      req_ch.flying  = 1'b0;
      req_beats      = 0;
      req_no_gaps    = 1'b0;
      cur_scale         = SCALE_RST;
      cur_overdischarge = OVERDISCHARGE_RST;
      cur_alarm         = ALARM_RST;
      cur_charge        = CHARGE_RST;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed groups at reset settings
      send_group(0, 0, 1'b1, 1'b0);          // zero code, charge low
      send_group(4095, 4095, 1'b1, 1'b0);    // full scale on the ground
      send_group(2000, 2000, 1'b0, 1'b1);    // flying below over-discharge
      send_group(2004, 2000, 1'b1, 1'b0);    // ground alarm band, counter held, mean truncated
      send_group(2209, 2204, 1'b0, 1'b1);    // flying inside the margin, counter cleared
      run_phase(27);

      // extremes, then random settings, then back to reset values
      program_csrs(65535, 65535, 65535, 0);
      run_phase(27);
      program_csrs(0, 0, 0, 0);
      run_phase(27);
      program_csrs(65535, 0, 0, 65535);
      run_phase(27);
      for (p = 0; p < 2; p++) begin
         program_csrs($urandom_range(3000, 8000), $urandom_range(1000, 5000),
                      $urandom_range(1000, 6000), $urandom_range(0, 4000));
         run_phase(27);
      end
      program_csrs($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
      run_phase(27);
      program_csrs(SCALE_RST, OVERDISCHARGE_RST, ALARM_RST, CHARGE_RST);
      run_phase(27);

      if (mismatch_total == 0 && readings_waiting == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
